// ===== hw/rtl/gbpe_pkg.sv =====
// Package for the glyph bitmap pixel emitter.
// Holds display and glyph size constants, field widths and the sequencer state type.
// Used by glyph_bitmap_pixel_emitter; it depends on nothing else.
package gbpe_pkg;

   // Display and glyph geometry.
   localparam int DISPLAY_WIDTH  = 128;
   localparam int DISPLAY_HEIGHT = 64;
   localparam int MAX_GLYPH_SIDE = 64;

   // Field and internal widths.
   localparam int COORD_W  = 18;
   localparam int SIDE_W   = 7;
   localparam int PIX_X_W  = 7;
   localparam int PIX_Y_W  = 6;
   localparam int BYTE_W   = 8;
   localparam int BIT_IDX_W = 3;

   // Input kinds carried on tuser.
   localparam logic ACTION_BEGIN = 1'b0;
   localparam logic ACTION_BYTE  = 1'b1;

   // Configuration register indexes.
   localparam logic REG_FONT_HEIGHT = 1'b0;
   localparam logic REG_BASE_RISE   = 1'b1;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ORG_X,
      ST_ORG_Y_LH,
      ST_ORG_Y_BL,
      ST_ORG_Y_BH,
      ST_ORG_Y_OY,
      ST_WALK,
      ST_FLUSH
   } state_type;

   // Saturate a box side at the largest glyph size.
   function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
      logic [SIDE_W-1:0] r;
      r = v;
      if (v > SIDE_W'(MAX_GLYPH_SIDE)) begin
         r = SIDE_W'(MAX_GLYPH_SIDE);
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/glyph_bitmap_pixel_emitter.sv =====
// Top level of the glyph bitmap pixel emitter.
// Turns glyph begin transfers and bitmap bytes into clipped display pixel coordinates.
// Depends on gbpe_pkg.
//
//   Channel   Direction  Payload
//   req_*     in         tuser: action; tdata: pen_x, pen_y, offset_x, offset_y,
//                        box_width, box_height, data_byte
//   rsp_*     out        tdata: pixel_x, pixel_y; tlast: last lit pixel of a byte
//   csr_*     in         write enable, register index, 8-bit write data
//
// A begin transfer is the transfer, then five passes through the shared 18-bit
// add/subtract unit that builds the glyph origin.
// A bitmap byte is the transfer, a walk over its bits and a hand-over of the held pixel;
// a walk that reaches the end of the box stops early, and a stalled result channel
// holds the walk and the hand-over.
// One pixel is held back so that the final one of each byte can carry tlast.
// Reset is synchronous and active high; req_tready is high only in the idle state.
module glyph_bitmap_pixel_emitter (
   input  logic        clock,
   input  logic        reset,
   // Input channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // pen_x, pen_y, offset_x, offset_y, box_width,
                                   // box_height, data_byte, two zero bits
   input  logic        req_tuser,  // action
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // pixel_x, pixel_y, three zero bits
   output logic        rsp_tlast,
   // Configuration port.
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   // Unpacked input fields.
   logic signed [15:0] pen_x;
   logic signed [15:0] pen_y;
   logic signed [7:0]  offset_x;
   logic signed [7:0]  offset_y;
   logic [gbpe_pkg::SIDE_W-1:0] box_width;
   logic [gbpe_pkg::SIDE_W-1:0] box_height;
   logic [gbpe_pkg::BYTE_W-1:0] data_byte;

   assign pen_x      = req_tdata[15:0];
   assign pen_y      = req_tdata[31:16];
   assign offset_x   = req_tdata[39:32];
   assign offset_y   = req_tdata[47:40];
   assign box_width  = req_tdata[54:48];
   assign box_height = req_tdata[61:55];
   assign data_byte  = req_tdata[69:62];

   // Registers.
   gbpe_pkg::state_type state_ff, state_in;
   logic [7:0] font_height_ff, font_height_in;
   logic [7:0] base_rise_ff, base_rise_in;
   logic signed [gbpe_pkg::COORD_W-1:0] origin_x_ff, origin_x_in;
   logic signed [gbpe_pkg::COORD_W-1:0] cur_x_ff, cur_x_in;
   logic signed [gbpe_pkg::COORD_W-1:0] cur_y_ff, cur_y_in;
   logic signed [gbpe_pkg::COORD_W-1:0] acc_ff, acc_in;
   logic [gbpe_pkg::SIDE_W-1:0] width_ff, width_in;
   logic [gbpe_pkg::SIDE_W-1:0] height_ff, height_in;
   logic [gbpe_pkg::SIDE_W-1:0] col_ff, col_in;
   logic [gbpe_pkg::SIDE_W-1:0] row_ff, row_in;
   logic [gbpe_pkg::BIT_IDX_W-1:0] bit_idx_ff, bit_idx_in;
   logic [gbpe_pkg::BYTE_W-1:0] byte_ff, byte_in;
   logic signed [15:0] pen_x_ff, pen_x_in;
   logic signed [15:0] pen_y_ff, pen_y_in;
   logic signed [7:0]  off_x_ff, off_x_in;
   logic signed [7:0]  off_y_ff, off_y_in;
   logic pend_valid_ff, pend_valid_in;
   logic [gbpe_pkg::PIX_X_W-1:0] pend_x_ff, pend_x_in;
   logic [gbpe_pkg::PIX_Y_W-1:0] pend_y_ff, pend_y_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [gbpe_pkg::PIX_X_W-1:0] rsp_x_ff, rsp_x_in;
   logic [gbpe_pkg::PIX_Y_W-1:0] rsp_y_ff, rsp_y_in;
   logic rsp_last_ff, rsp_last_in;

   // Shared add/subtract unit.
   logic signed [gbpe_pkg::COORD_W-1:0] add_a;
   logic signed [gbpe_pkg::COORD_W-1:0] add_b;
   logic add_sub;
   logic signed [gbpe_pkg::COORD_W-1:0] add_sum;

   // Walk control.
   logic req_xfer;
   logic out_free;
   logic walk_stop;
   logic on_display;
   logic hit;
   logic step_en;
   logic row_wrap;
   logic [gbpe_pkg::SIDE_W-1:0] col_next;

   assign req_xfer = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // The bitmap walk ends for an empty box or once every row has been read.
   assign walk_stop = (width_ff == '0) || (row_ff >= height_ff);

   // Clipping against the display.
   assign on_display = !cur_x_ff[gbpe_pkg::COORD_W-1]
                    && !cur_y_ff[gbpe_pkg::COORD_W-1]
                    && (cur_x_ff < gbpe_pkg::COORD_W'(gbpe_pkg::DISPLAY_WIDTH))
                    && (cur_y_ff < gbpe_pkg::COORD_W'(gbpe_pkg::DISPLAY_HEIGHT));
   assign hit = byte_ff[gbpe_pkg::BYTE_W-1] && on_display;

   // A new pixel pushes the held one out, which needs a free output register.
   assign step_en  = !(hit && pend_valid_ff) || out_free;
   assign col_next = col_ff + gbpe_pkg::SIDE_W'(1);
   assign row_wrap = (col_next >= width_ff);

   // Operand selection for the shared unit.
   always_comb begin
      add_a   = acc_ff;
      add_b   = '0;
      add_sub = 1'b0;
      case (state_ff)
         gbpe_pkg::ST_ORG_X: begin
            add_a = gbpe_pkg::COORD_W'(pen_x_ff);
            add_b = gbpe_pkg::COORD_W'(off_x_ff);
         end
         gbpe_pkg::ST_ORG_Y_LH: begin
            add_a = gbpe_pkg::COORD_W'(pen_y_ff);
            add_b = gbpe_pkg::COORD_W'(font_height_ff);
         end
         gbpe_pkg::ST_ORG_Y_BL: begin
            add_b   = gbpe_pkg::COORD_W'(signed'(base_rise_ff));
            add_sub = 1'b1;
         end
         gbpe_pkg::ST_ORG_Y_BH: begin
            add_b   = gbpe_pkg::COORD_W'(height_ff);
            add_sub = 1'b1;
         end
         gbpe_pkg::ST_ORG_Y_OY: begin
            add_b   = gbpe_pkg::COORD_W'(off_y_ff);
            add_sub = 1'b1;
         end
         default: begin
            add_a = acc_ff;
         end
      endcase
   end

   assign add_sum = add_sub ? (add_a - add_b) : (add_a + add_b);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gbpe_pkg::ST_IDLE: begin
            if (req_xfer) begin
               state_in = (req_tuser == gbpe_pkg::ACTION_BEGIN) ? gbpe_pkg::ST_ORG_X
                                                                : gbpe_pkg::ST_WALK;
            end
         end
         gbpe_pkg::ST_ORG_X:    state_in = gbpe_pkg::ST_ORG_Y_LH;
         gbpe_pkg::ST_ORG_Y_LH: state_in = gbpe_pkg::ST_ORG_Y_BL;
         gbpe_pkg::ST_ORG_Y_BL: state_in = gbpe_pkg::ST_ORG_Y_BH;
         gbpe_pkg::ST_ORG_Y_BH: state_in = gbpe_pkg::ST_ORG_Y_OY;
         gbpe_pkg::ST_ORG_Y_OY: state_in = gbpe_pkg::ST_IDLE;
         gbpe_pkg::ST_WALK: begin
            if (walk_stop) begin
               state_in = gbpe_pkg::ST_FLUSH;
            end else if (step_en && (bit_idx_ff == '1)) begin
               state_in = gbpe_pkg::ST_FLUSH;
            end
         end
         gbpe_pkg::ST_FLUSH: begin
            if (!pend_valid_ff || out_free) begin
               state_in = gbpe_pkg::ST_IDLE;
            end
         end
         default: state_in = gbpe_pkg::ST_IDLE;
      endcase
   end

   // Datapath and output register updates.
   always_comb begin
      font_height_in = font_height_ff;
      base_rise_in   = base_rise_ff;
      origin_x_in    = origin_x_ff;
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      acc_in         = acc_ff;
      width_in       = width_ff;
      height_in      = height_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      bit_idx_in     = bit_idx_ff;
      byte_in        = byte_ff;
      pen_x_in       = pen_x_ff;
      pen_y_in       = pen_y_ff;
      off_x_in       = off_x_ff;
      off_y_in       = off_y_ff;
      pend_valid_in  = pend_valid_ff;
      pend_x_in      = pend_x_ff;
      pend_y_in      = pend_y_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_last_in    = rsp_last_ff;

      // Configuration writes.
      if (csr_we) begin
         case (csr_index)
            gbpe_pkg::REG_FONT_HEIGHT: font_height_in = csr_wdata;
            gbpe_pkg::REG_BASE_RISE:   base_rise_in   = csr_wdata;
            default:                   font_height_in = font_height_ff;
         endcase
      end

      case (state_ff)
         gbpe_pkg::ST_IDLE: begin
            if (req_xfer) begin
               if (req_tuser == gbpe_pkg::ACTION_BEGIN) begin
                  pen_x_in  = pen_x;
                  pen_y_in  = pen_y;
                  off_x_in  = offset_x;
                  off_y_in  = offset_y;
                  width_in  = gbpe_pkg::clamp_side(box_width);
                  height_in = gbpe_pkg::clamp_side(box_height);
                  col_in    = '0;
                  row_in    = '0;
               end else begin
                  byte_in    = data_byte;
                  bit_idx_in = '0;
               end
            end
         end
         gbpe_pkg::ST_ORG_X: begin
            origin_x_in = add_sum;
            cur_x_in    = add_sum;
         end
         gbpe_pkg::ST_ORG_Y_LH,
         gbpe_pkg::ST_ORG_Y_BL,
         gbpe_pkg::ST_ORG_Y_BH: begin
            acc_in = add_sum;
         end
         gbpe_pkg::ST_ORG_Y_OY: begin
            cur_y_in = add_sum;
         end
         gbpe_pkg::ST_WALK: begin
            if (!walk_stop && step_en) begin
               // Hold the new pixel and send the one held before it.
               if (hit) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_x_in     = pend_x_ff;
                     rsp_y_in     = pend_y_ff;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_x_in     = cur_x_ff[gbpe_pkg::PIX_X_W-1:0];
                  pend_y_in     = cur_y_ff[gbpe_pkg::PIX_Y_W-1:0];
               end
               // Advance the cursor through the box, row by row.
               if (row_wrap) begin
                  col_in   = '0;
                  row_in   = row_ff + gbpe_pkg::SIDE_W'(1);
                  cur_x_in = origin_x_ff;
                  cur_y_in = cur_y_ff + gbpe_pkg::COORD_W'(1);
               end else begin
                  col_in   = col_next;
                  cur_x_in = cur_x_ff + gbpe_pkg::COORD_W'(1);
               end
               byte_in    = {byte_ff[gbpe_pkg::BYTE_W-2:0], 1'b0};
               bit_idx_in = bit_idx_ff + gbpe_pkg::BIT_IDX_W'(1);
            end
         end
         gbpe_pkg::ST_FLUSH: begin
            // The held pixel is the final one of this byte.
            if (pend_valid_ff && out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_x_in      = pend_x_ff;
               rsp_y_in      = pend_y_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
         default: begin
            pend_valid_in = pend_valid_ff;
         end
      endcase
   end

   // Control and glyph state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= gbpe_pkg::ST_IDLE;
         font_height_ff <= 8'd16;
         base_rise_ff   <= 8'd3;
         origin_x_ff    <= '0;
         cur_x_ff       <= '0;
         cur_y_ff       <= '0;
         width_ff       <= '0;
         height_ff      <= '0;
         col_ff         <= '0;
         row_ff         <= '0;
         bit_idx_ff     <= '0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         font_height_ff <= font_height_in;
         base_rise_ff   <= base_rise_in;
         origin_x_ff    <= origin_x_in;
         cur_x_ff       <= cur_x_in;
         cur_y_ff       <= cur_y_in;
         width_ff       <= width_in;
         height_ff      <= height_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         bit_idx_ff     <= bit_idx_in;
         pend_valid_ff  <= pend_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      byte_ff     <= byte_in;
      pen_x_ff    <= pen_x_in;
      pen_y_ff    <= pen_y_in;
      off_x_ff    <= off_x_in;
      off_y_ff    <= off_y_in;
      pend_x_ff   <= pend_x_in;
      pend_y_ff   <= pend_y_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Port outputs.
   assign req_tready = (state_ff == gbpe_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_y_ff, rsp_x_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // No pixel is left behind when the block goes idle.
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gbpe_pkg::ST_IDLE) |-> !pend_valid_ff)
      else $error("held pixel left over in idle state");

   // Latched box sides never exceed the largest glyph size.
   a_side_clamped: assert property (@(posedge clock) disable iff (reset)
      (width_ff <= gbpe_pkg::SIDE_W'(gbpe_pkg::MAX_GLYPH_SIDE))
      && (height_ff <= gbpe_pkg::SIDE_W'(gbpe_pkg::MAX_GLYPH_SIDE)))
      else $error("box side above the glyph limit");

   // The column stays inside a non-empty box during the walk.
   a_col_in_box: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == gbpe_pkg::ST_WALK) && (width_ff != '0)) |-> (col_ff < width_ff))
      else $error("column beyond box width");

   // The row never runs past the box height.
   a_row_in_box: assert property (@(posedge clock) disable iff (reset)
      (row_ff <= height_ff) || (state_ff == gbpe_pkg::ST_IDLE))
      else $error("row beyond box height");

   // Draining the held pixel presents it as the final one of the byte.
   a_flush_last: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == gbpe_pkg::ST_FLUSH) && pend_valid_ff && out_free)
      |=> (rsp_tvalid && rsp_tlast))
      else $error("final pixel of a byte not marked");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for glyph_bitmap_pixel_emitter.
// Drives glyph begin and bitmap byte transfers, predicts every lit pixel and checks it.
// Depends on gbpe_pkg and the glyph_bitmap_pixel_emitter RTL only.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 24;
   localparam int TARGET_ITEMS  = 470;
   localparam int HOLD_OFF_LEN  = 300;

   // One input transfer, unpacked by field.
   typedef struct {
      logic               action;
      logic signed [15:0] pen_x;
      logic signed [15:0] pen_y;
      logic signed [7:0]  off_x;
      logic signed [7:0]  off_y;
      logic [6:0]         box_w;
      logic [6:0]         box_h;
      logic [7:0]         bits;
   } glyph_req_type;

   // One expected lit pixel.
   typedef struct {
      logic [6:0] x;
      logic [5:0] y;
      logic       last;
   } pixel_type;

   typedef enum {FILL_RANDOM, FILL_SOLID, FILL_SPARSE, FILL_EMPTY} fill_kind_type;
   typedef enum {RX_STEADY, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_pattern_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;  // pen_x, pen_y, offset_x, offset_y, box_width,
                                 // box_height, data_byte, two zero bits
   logic        req_tuser = gbpe_pkg::ACTION_BEGIN;  // action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;  // pixel_x, pixel_y, three zero bits
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic        csr_index = gbpe_pkg::REG_FONT_HEIGHT;
   logic [7:0]  csr_wdata = '0;

   glyph_bitmap_pixel_emitter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Shadow of the block's registers and walk state.
   logic [7:0]        font_height_q = 8'd16;
   logic signed [7:0] base_rise_q   = 8'sd3;
   int                org_x = 0;
   int                org_y = 0;
   int                held_w = 0;
   int                held_h = 0;
   int                col_at = 0;
   int                row_at = 0;

   pixel_type pixel_expect_q[$];

   int mismatch_count = 0;
   int pixels_checked = 0;
   int counted_items  = 0;
   int glyphs_run     = 0;
   int bytes_sent     = 0;
   int csr_writes     = 0;
   int burst_left     = 0;
   int hold_off_len   = 0;
   int longest_hold   = 0;
   int cycle_count    = 0;

   // Clock.
   initial begin
      forever #5 clock = ~clock;
   end

   // Run-length guard.
   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pixels still expected", cycle_count,
                     pixel_expect_q.size());
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Mismatch reporting; printing is capped so a broken block does not flood the log.
   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 40) begin
         $display("mismatch at cycle %0d: %s", cycle_count, what);
      end
   endtask

   // Box sides saturate at the largest glyph size.
   function automatic int side_of(input int raw);
      int s;
      s = raw & 8'h7f;
      if (s > gbpe_pkg::MAX_GLYPH_SIDE) begin
         s = gbpe_pkg::MAX_GLYPH_SIDE;
      end
      return s;
   endfunction

   // Pen row that puts the glyph's top row at the wanted display row.
   function automatic int pen_y_for(input int top_row, input int box_h, input int off_y);
      return top_row - int'(font_height_q) + int'(base_rise_q) + side_of(box_h) + off_y;
   endfunction

   // Advance the shadow state by one accepted transfer and queue the pixels it lights.
   task automatic predict_lit_pixels(input glyph_req_type it);
      pixel_type lit[$];
      pixel_type p;
      int        x;
      int        y;
      if (it.action == gbpe_pkg::ACTION_BEGIN) begin
         held_w = side_of(int'(it.box_w));
         held_h = side_of(int'(it.box_h));
         org_x  = int'(it.pen_x) + int'(it.off_x);
         org_y  = int'(it.pen_y) + int'(font_height_q) - int'(base_rise_q) - held_h
                  - int'(it.off_y);
         col_at = 0;
         row_at = 0;
      end else begin
         for (int b = 7; b >= 0; b--) begin
            if (held_w == 0 || row_at >= held_h) break;
            if (it.bits[b]) begin
               x = org_x + col_at;
               y = org_y + row_at;
               if (x >= 0 && y >= 0 && x < gbpe_pkg::DISPLAY_WIDTH
                   && y < gbpe_pkg::DISPLAY_HEIGHT) begin
                  p.x    = x[6:0];
                  p.y    = y[5:0];
                  p.last = 1'b0;
                  lit.push_back(p);
               end
            end
            col_at++;
            if (col_at >= held_w) begin
               col_at = 0;
               row_at++;
            end
         end
         // The final lit pixel of a byte carries tlast.
         if (lit.size() > 0) begin
            lit[lit.size() - 1].last = 1'b1;
         end
         foreach (lit[i]) pixel_expect_q.push_back(lit[i]);
      end
   endtask

   function automatic glyph_req_type make_begin(input int pen_x, input int pen_y,
                                                input int off_x, input int off_y,
                                                input int box_w, input int box_h);
      glyph_req_type it;
      it.action = gbpe_pkg::ACTION_BEGIN;
      it.pen_x  = pen_x[15:0];
      it.pen_y  = pen_y[15:0];
      it.off_x  = off_x[7:0];
      it.off_y  = off_y[7:0];
      it.box_w  = box_w[6:0];
      it.box_h  = box_h[6:0];
      it.bits   = 8'($urandom);
      return it;
   endfunction

   // Bitmap byte; the geometry fields carry random junk the block must ignore.
   function automatic glyph_req_type make_byte(input logic [7:0] bits);
      glyph_req_type it;
      it.action = gbpe_pkg::ACTION_BYTE;
      it.pen_x  = 16'($urandom);
      it.pen_y  = 16'($urandom);
      it.off_x  = 8'($urandom);
      it.off_y  = 8'($urandom);
      it.box_w  = 7'($urandom);
      it.box_h  = 7'($urandom);
      it.bits   = bits;
      return it;
   endfunction

   // Send one transfer. The sender works in bursts with random gaps in between, and
   // tvalid stays high from one transfer to the next inside a burst.
   task automatic push_item(input glyph_req_type it);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= it.action;
      req_tdata  <= {2'b00, it.bits, it.box_h, it.box_w, it.off_y, it.off_x,
                     it.pen_y, it.pen_x};
      do @(posedge clock); while (!req_tready);
      predict_lit_pixels(it);
      if (it.action == gbpe_pkg::ACTION_BYTE) bytes_sent++;
      counted_items++;
      burst_left--;
   endtask

   // Stop sending, wait for every expected pixel and let a pixel-free walk finish.
   task automatic drain_and_settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pixel_expect_q.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write; only called while the block is idle.
   task automatic write_csr(input logic index, input logic [7:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      if (index == gbpe_pkg::REG_FONT_HEIGHT) font_height_q = value;
      else base_rise_q = value;
      csr_writes++;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_font_metrics(input int font_height, input int base_rise);
      drain_and_settle();
      write_csr(gbpe_pkg::REG_FONT_HEIGHT, font_height[7:0]);
      write_csr(gbpe_pkg::REG_BASE_RISE, base_rise[7:0]);
   endtask

   function automatic logic [7:0] fill_byte(input fill_kind_type fill);
      case (fill)
         FILL_SOLID:  return 8'hff;
         FILL_SPARSE: return 8'h80 >> $urandom_range(0, 7);
         FILL_EMPTY:  return 8'h00;
         default:     return 8'($urandom);
      endcase
   endfunction

   // Begin transfer followed by its bitmap bytes, with optional surplus or cut bytes.
   task automatic run_glyph(input int pen_x, input int pen_y, input int off_x, input int off_y,
                            input int box_w, input int box_h, input fill_kind_type fill,
                            input int surplus, input int cut);
      int need;
      need = (side_of(box_w) * side_of(box_h) + 7) / 8;
      push_item(make_begin(pen_x, pen_y, off_x, off_y, box_w, box_h));
      glyphs_run++;
      for (int i = 0; i < need - cut + surplus; i++) begin
         push_item(make_byte(fill_byte(fill)));
      end
   endtask

   // Result checking: every accepted pixel against the oldest expectation.
   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         pixels_checked++;
         if (pixel_expect_q.size() == 0) begin
            report_mismatch($sformatf("unexpected pixel x=%0d y=%0d last=%0b",
                                      rsp_tdata[6:0], rsp_tdata[12:7], rsp_tlast));
         end else begin
            want = pixel_expect_q.pop_front();
            if (rsp_tdata[6:0] != want.x)
               report_mismatch($sformatf("pixel_x %0d, expected %0d", rsp_tdata[6:0], want.x));
            if (rsp_tdata[12:7] != want.y)
               report_mismatch($sformatf("pixel_y %0d, expected %0d", rsp_tdata[12:7], want.y));
            if (rsp_tlast != want.last)
               report_mismatch($sformatf("tlast %0b, expected %0b", rsp_tlast, want.last));
         end
      end
   end

   // Receiver: switches between stall patterns, and on request holds off for a long
   // stretch so the block backs up into its input channel.
   initial begin
      int             stall_left;
      int             phase_left;
      rx_pattern_type pattern;
      stall_left = 0;
      phase_left = 0;
      pattern    = RX_STEADY;
      forever begin
         @(negedge clock);
         if (hold_off_len > 0) begin
            stall_left = hold_off_len;
            if (hold_off_len > longest_hold) longest_hold = hold_off_len;
            hold_off_len = 0;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            if (phase_left == 0) begin
               pattern    = rx_pattern_type'($urandom_range(0, 3));
               phase_left = $urandom_range(16, 96);
            end
            phase_left--;
            case (pattern)
               RX_STEADY:   rsp_tready <= 1'b1;
               RX_COIN:     rsp_tready <= 1'($urandom_range(0, 1));
               RX_SPARSE:   rsp_tready <= ($urandom_range(0, 3) == 0);
               default:     rsp_tready <= ((phase_left % 5) >= 2);
            endcase
         end
      end
   end

   // A byte ahead of any begin, then a small glyph under the reset font metrics.
   task automatic test_reset_defaults();
      push_item(make_byte(8'hff));
      run_glyph(10, 10, 2, 1, 8, 3, FILL_RANDOM, 0, 0);
      push_item(make_byte(8'ha5));
   endtask

   // Field extremes, empty boxes, oversized boxes, surplus bytes and clipping.
   task automatic test_field_extremes();
      run_glyph(-32768, -32768, -128, -128, 8, 1, FILL_SOLID, 0, 0);
      run_glyph(32767, 32767, 127, 127, 8, 1, FILL_SOLID, 0, 0);
      run_glyph(5, 5, 0, 0, 0, 5, FILL_SOLID, 1, 0);
      run_glyph(5, 5, 0, 0, 5, 0, FILL_SOLID, 1, 0);
      // Oversized width saturates; the right part runs off the display.
      run_glyph(100, pen_y_for(5, 1, 0), 0, 0, 127, 1, FILL_SOLID, 1, 0);
      // Glyph hanging over the left and top edges.
      run_glyph(-3, pen_y_for(-2, 4, 0), 0, 0, 6, 4, FILL_SOLID, 0, 0);
      run_glyph(0, pen_y_for(0, 2, 0), 0, 0, 8, 2, FILL_EMPTY, 0, 0);
      push_item(make_byte(8'h01));
   endtask

   // Long receiver hold-off while a dense glyph keeps the sender busy.
   task automatic test_result_backpressure();
      drain_and_settle();
      hold_off_len = HOLD_OFF_LEN;
      run_glyph(20, pen_y_for(10, 8, 0), 0, 0, 16, 8, FILL_SOLID, 0, 0);
   endtask

   // Font metric extremes, each followed by a glyph placed on the display.
   task automatic test_register_extremes();
      int lh[4] = '{255, 1, 255, 1};
      int bl[4] = '{-128, 127, 127, -128};
      for (int i = 0; i < 4; i++) begin
         set_font_metrics(lh[i], bl[i]);
         run_glyph(30 + 10 * i, pen_y_for(20, 5, 3), 0, 3, 7, 5, FILL_RANDOM, 0, 0);
      end
   endtask

   task automatic random_glyph();
      int sel;
      int w;
      int h;
      int ox;
      int oy;
      int px;
      int py;
      int need;
      int surplus;
      int cut;
      sel = $urandom_range(0, 99);
      if (sel < 80) begin
         w = $urandom_range(1, 12);
         h = $urandom_range(1, 12);
      end else if (sel < 90) begin
         w = $urandom_range(13, 64);
         h = $urandom_range(1, 3);
         if ($urandom_range(0, 1) == 1) begin
            h = w;
            w = $urandom_range(1, 3);
         end
      end else if (sel < 95) begin
         w = $urandom_range(65, 127);
         h = 1;
         if ($urandom_range(0, 1) == 1) begin
            h = w;
            w = 1;
         end
      end else begin
         w = 0;
         h = $urandom_range(0, 10);
         if ($urandom_range(0, 1) == 1) begin
            w = h;
            h = 0;
         end
      end
      if ($urandom_range(0, 9) == 0) begin
         px = int'(16'($urandom));
         py = int'(16'($urandom));
         ox = int'(8'($urandom));
         oy = int'(8'($urandom));
      end else begin
         ox = $urandom_range(0, 16) - 8;
         oy = $urandom_range(0, 16) - 8;
         px = $urandom_range(0, 160) - 30;
         py = pen_y_for($urandom_range(0, 80) - 10, h, oy);
      end
      need    = (side_of(w) * side_of(h) + 7) / 8;
      surplus = (need == 0 || $urandom_range(0, 6) == 0) ? $urandom_range(1, 3) : 0;
      cut     = (need > 0 && $urandom_range(0, 9) == 0) ? $urandom_range(1, need) : 0;
      run_glyph(px, py, ox, oy, w, h, fill_kind_type'($urandom_range(0, 3)), surplus, cut);
   endtask

   // Mostly well-formed glyphs with random content; the rest is stray bytes and
   // begins with every field random. Font metrics change between phases.
   task automatic test_random_traffic();
      int next_metrics;
      int lh;
      int bl;
      next_metrics = counted_items + 90;
      while (counted_items < TARGET_ITEMS) begin
         if (counted_items >= next_metrics) begin
            case ($urandom_range(0, 3))
               0:       lh = 1;
               1:       lh = 255;
               default: lh = $urandom_range(1, 255);
            endcase
            case ($urandom_range(0, 3))
               0:       bl = -128;
               1:       bl = 127;
               default: bl = $urandom_range(0, 255) - 128;
            endcase
            set_font_metrics(lh, bl);
            next_metrics = counted_items + 90;
         end
         if ($urandom_range(0, 99) < 85) begin
            random_glyph();
         end else if ($urandom_range(0, 1) == 0) begin
            push_item(make_byte(8'($urandom)));
         end else begin
            push_item(make_begin(int'($urandom), int'($urandom), int'($urandom),
                                 int'($urandom), int'($urandom), int'($urandom)));
         end
      end
   endtask

   // Test sequence.
   initial begin : run_all
      int wait_left;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_field_extremes();
      test_result_backpressure();
      test_register_extremes();
      test_random_traffic();

      @(negedge clock);
      req_tvalid <= 1'b0;
      wait_left = 20000;
      while (pixel_expect_q.size() > 0 && wait_left > 0) begin
         @(posedge clock);
         wait_left--;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      foreach (pixel_expect_q[i]) begin
         report_mismatch($sformatf("pixel x=%0d y=%0d never arrived",
                                   pixel_expect_q[i].x, pixel_expect_q[i].y));
      end

      $display("covered %0d glyphs, %0d bitmap bytes and %0d register writes",
               glyphs_run, bytes_sent, csr_writes);
      $display("checked %0d pixels, longest receiver hold-off %0d cycles, %0d mismatches",
               pixels_checked, longest_hold, mismatch_count);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/gbpe_pkg.sv
hw/rtl/glyph_bitmap_pixel_emitter.sv
tb/sv/tb.sv
